/* rtl/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants for the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

    // bracket kinds as stored on the stack
    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_CURLY  = 2'd1,
        KIND_SQUARE = 2'd2
    } t_kind;

    // reported error codes
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_EMPTY    = 3'd1,
        ERR_ROUND    = 3'd2,
        ERR_CURLY    = 3'd3,
        ERR_SQUARE   = 3'd4,
        ERR_UNCLOSED = 3'd5,
        ERR_OVERFLOW = 3'd6
    } t_err;

    // bracket characters
    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;  // (
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;  // )
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;  // [
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;  // ]
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;  // {
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;  // }

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QLVL_W      = 3;

    // classified byte handed to the stack engine
    typedef struct packed {
        logic  is_open;
        logic  is_close;
        t_kind kind;
        logic  is_last;
    } t_token;

    // error for a closer whose kind does not match the top of stack
    function automatic t_err kind_mismatch(input t_kind k);
        t_err e;
        case (k)
            KIND_ROUND:  e = ERR_ROUND;
            KIND_CURLY:  e = ERR_CURLY;
            KIND_SQUARE: e = ERR_SQUARE;
            default:     e = ERR_ROUND;
        endcase
        return e;
    endfunction

endpackage

/* rtl/bracket_balance_checker_core.sv */
// ----------------------------------------------------------------------------
// bracket_balance_checker_core
// Checks bracket balance of a byte stream, one result per string.
// Result path: a last byte's token is written to the token queue, then its result to the result register.
// Throughput: 1 byte per cycle while the token queue is not full, set by the stack step that
// keeps the top two entries in registers and prefetches the third.
// Reset: synchronous; clears queue, stack count, error and result valid.
// Stack memory is not cleared; entries are only read once written.
// ----------------------------------------------------------------------------
module bracket_balance_checker_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_byte,
    input  logic       i_is_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_valid_res,
    output logic [2:0] o_error_code
);
    import bbc_pkg::*;

    t_token f_tok;
    t_token q_tok;
    logic   f_push;
    logic   q_full;
    logic   q_nonempty;
    logic   q_pop;

    // classifier
    bbc_front u_front (
        .i_in_valid  (i_in_valid),
        .i_char_byte (i_char_byte),
        .i_is_last   (i_is_last),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (f_push),
        .o_tok       (f_tok)
    );

    // token queue
    bbc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (f_push),
        .i_tok      (f_tok),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_tok      (q_tok)
    );

    // stack engine
    bbc_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tok_valid  (q_nonempty),
        .i_tok        (q_tok),
        .o_tok_pop    (q_pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_valid_res  (o_valid_res),
        .o_error_code (o_error_code)
    );

endmodule

/* rtl/bbc_front.sv */
// ----------------------------------------------------------------------------
// bbc_front
// Input side: accepts bytes, classifies brackets and queues tokens.
// ----------------------------------------------------------------------------
module bbc_front (
    input  logic            i_in_valid,
    input  logic [7:0]      i_char_byte,
    input  logic            i_is_last,
    input  logic            i_q_full,
    output logic            o_in_stall,
    output logic            o_push,
    output bbc_pkg::t_token o_tok
);
    import bbc_pkg::*;

    logic is_bracket;

    // decode the byte into opener / closer and kind
    always_comb begin
        o_tok.is_open  = 1'b0;
        o_tok.is_close = 1'b0;
        o_tok.kind     = KIND_ROUND;
        o_tok.is_last  = i_is_last;
        case (i_char_byte)
            CH_OPEN_ROUND: begin
                o_tok.is_open = 1'b1;
                o_tok.kind    = KIND_ROUND;
            end
            CH_OPEN_CURLY: begin
                o_tok.is_open = 1'b1;
                o_tok.kind    = KIND_CURLY;
            end
            CH_OPEN_SQUARE: begin
                o_tok.is_open = 1'b1;
                o_tok.kind    = KIND_SQUARE;
            end
            CH_CLOSE_ROUND: begin
                o_tok.is_close = 1'b1;
                o_tok.kind     = KIND_ROUND;
            end
            CH_CLOSE_CURLY: begin
                o_tok.is_close = 1'b1;
                o_tok.kind     = KIND_CURLY;
            end
            CH_CLOSE_SQUARE: begin
                o_tok.is_close = 1'b1;
                o_tok.kind     = KIND_SQUARE;
            end
            default: begin
                o_tok.is_open  = 1'b0;
                o_tok.is_close = 1'b0;
            end
        endcase
    end

    assign is_bracket = o_tok.is_open | o_tok.is_close;

    // plain characters are dropped unless they end the string
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full & (is_bracket | i_is_last);

endmodule

/* rtl/bbc_queue.sv */
// ----------------------------------------------------------------------------
// bbc_queue
// Small token FIFO decoupling the classifier from the stack engine.
// ----------------------------------------------------------------------------
module bbc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bbc_pkg::t_token i_tok,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output bbc_pkg::t_token o_tok
);
    import bbc_pkg::*;

    t_token              r_data [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QLVL_W-1:0]   r_level;
    logic [QLVL_W-1:0]   n_level;

    assign o_full     = (r_level == QLVL_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_level != '0);
    assign o_tok      = r_data[r_rd_ptr];

    // fill level
    always_comb begin
        n_level = r_level;
        case ({i_push, i_pop})
            2'b10:   n_level = r_level + QLVL_W'(1);
            2'b01:   n_level = r_level - QLVL_W'(1);
            default: n_level = r_level;
        endcase
    end

    // pointers and level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            r_level <= n_level;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_data[r_wr_ptr] <= i_tok;
    end

endmodule

/* rtl/bbc_stack.sv */
// ----------------------------------------------------------------------------
// bbc_stack
// Back end: bracket stack with top two entries in registers, error latch
// and result register.
// ----------------------------------------------------------------------------
module bbc_stack #(
    parameter int STACK_DEPTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tok_valid,
    input  bbc_pkg::t_token i_tok,
    output logic            o_tok_pop,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic            o_valid_res,
    output logic [2:0]      o_error_code
);
    import bbc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    t_kind          r_mem [STACK_DEPTH];
    t_kind          r_top;
    t_kind          r_below;
    t_kind          r_rd;
    logic [CW-1:0]  r_count;
    t_err           r_err;
    logic           r_out_valid;
    logic           r_out_res;
    t_err           r_out_code;

    t_kind          n_top;
    t_kind          n_below;
    logic [CW-1:0]  s_count;
    t_err           s_err;
    logic [CW-1:0]  n_count;
    t_err           n_err;
    t_err           fin_code;
    logic           push;
    logic           slot_free;
    logic           fin_fire;
    logic [CW-1:0]  rd_full;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;

    // a final token needs the result register; others never wait
    assign slot_free = ~r_out_valid | ~i_out_stall;
    assign o_tok_pop = i_tok_valid & (~i_tok.is_last | slot_free);
    assign fin_fire  = o_tok_pop & i_tok.is_last;

    // stack step for one token
    always_comb begin
        s_count = r_count;
        s_err   = r_err;
        n_top   = r_top;
        n_below = r_below;
        push    = 1'b0;
        if (o_tok_pop && r_err == ERR_NONE) begin
            if (i_tok.is_open) begin
                if (r_count >= CW'(STACK_DEPTH)) begin
                    s_err = ERR_OVERFLOW;
                end else begin
                    push    = 1'b1;
                    s_count = r_count + CW'(1);
                    n_top   = i_tok.kind;
                    n_below = r_top;
                end
            end else if (i_tok.is_close) begin
                if (r_count == '0) begin
                    s_err = ERR_EMPTY;
                end else if (r_top != i_tok.kind) begin
                    s_err = kind_mismatch(i_tok.kind);
                end else begin
                    s_count = r_count - CW'(1);
                    n_top   = r_below;
                    n_below = r_rd;
                end
            end
        end
        // end-of-string verdict, then clear for the next string
        if (s_err != ERR_NONE)       fin_code = s_err;
        else if (s_count != '0)      fin_code = ERR_UNCLOSED;
        else                         fin_code = ERR_NONE;
        n_count = fin_fire ? '0 : s_count;
        n_err   = fin_fire ? ERR_NONE : s_err;
    end

    // prefetch the entry that sits third from the top after this cycle
    assign rd_full = n_count - CW'(3);
    assign rd_addr = rd_full[AW-1:0];
    assign wr_addr = r_count[AW-1:0];

    // stack memory
    always_ff @(posedge i_clk) begin
        if (push) r_mem[wr_addr] <= i_tok.kind;
        r_rd <= r_mem[rd_addr];
    end

    // stack control and error latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_err   <= ERR_NONE;
        end else begin
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    // top-of-stack cache
    always_ff @(posedge i_clk) begin
        r_top   <= n_top;
        r_below <= n_below;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= fin_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_fire) begin
            r_out_res  <= (fin_code == ERR_NONE);
            r_out_code <= fin_code;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_valid_res  = r_out_res;
    assign o_error_code = r_out_code;

endmodule

/* rtl/bbc_checker.sv */
// ----------------------------------------------------------------------------
// bbc_checker
// Port-level assertions for the bracket balance checker.
// ----------------------------------------------------------------------------
module bbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_valid_res,
    input logic [2:0] o_error_code
);
    import bbc_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_error_code) && $stable(o_valid_res))
        else $error("result changed while stalled");

    // valid flag agrees with the error code
    a_res_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_valid_res == (o_error_code == ERR_NONE)))
        else $error("valid_res disagrees with error_code");

    // code seven is never reported
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_error_code != 3'd7))
        else $error("undefined error code");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind bracket_balance_checker_core bbc_checker u_bbc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_valid_res  (o_valid_res),
    .o_error_code (o_error_code)
);

/* tb/bracket_balance_checker_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bracket_balance_checker_core_tb
// Self-checking bench for the bracket balance checker. A short table of
// strings covers every error code but overflow, and the byte extremes,
// some of them with typed expectations. Random well-formed, broken, noisy
// and deep strings follow and are checked against a behavioral stack model.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module bracket_balance_checker_core_tb;
    import bbc_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int ITEM_TARGET = 450;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    // directed string table: expected code typed only where marked
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        t_err       code;
    } t_row;

    localparam int NUM_ROWS = 25;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_char_byte = 8'h00;
    logic       i_is_last = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_valid_res;
    logic [2:0] o_error_code;

    // stack model state
    t_kind      open_kinds [STACK_DEPTH];
    int         open_count = 0;
    t_err       latched_err = ERR_NONE;

    t_err       expected_codes [$];
    logic [7:0] text_bytes [$];
    int         sent_items = 0;
    int         mismatch_count = 0;
    int         cycle_count = 0;
    logic       idle_on = 1'b1;
    logic       stall_on = 1'b1;

    t_row directed_rows [NUM_ROWS] = '{
        '{CH_OPEN_ROUND,   1'b1, 1'b1, ERR_UNCLOSED},
        '{CH_CLOSE_ROUND,  1'b1, 1'b1, ERR_EMPTY},
        '{8'h00,           1'b1, 1'b1, ERR_NONE},
        '{8'hFF,           1'b1, 1'b1, ERR_NONE},
        '{CH_OPEN_ROUND,   1'b0, 1'b0, ERR_NONE},
        '{CH_CLOSE_SQUARE, 1'b1, 1'b1, ERR_SQUARE},
        '{CH_OPEN_SQUARE,  1'b0, 1'b0, ERR_NONE},
        '{CH_CLOSE_CURLY,  1'b1, 1'b1, ERR_CURLY},
        '{CH_OPEN_CURLY,   1'b0, 1'b0, ERR_NONE},
        '{CH_CLOSE_ROUND,  1'b1, 1'b1, ERR_ROUND},
        // first error sticks over later bytes
        '{CH_CLOSE_ROUND,  1'b0, 1'b0, ERR_NONE},
        '{CH_OPEN_ROUND,   1'b0, 1'b0, ERR_NONE},
        '{CH_CLOSE_SQUARE, 1'b1, 1'b1, ERR_EMPTY},
        '{CH_OPEN_CURLY,   1'b0, 1'b0, ERR_NONE},
        '{CH_OPEN_SQUARE,  1'b0, 1'b0, ERR_NONE},
        '{8'h41,           1'b0, 1'b0, ERR_NONE},
        '{CH_CLOSE_SQUARE, 1'b0, 1'b0, ERR_NONE},
        '{CH_CLOSE_CURLY,  1'b1, 1'b0, ERR_NONE},
        '{CH_OPEN_ROUND,   1'b0, 1'b0, ERR_NONE},
        '{CH_OPEN_ROUND,   1'b0, 1'b0, ERR_NONE},
        '{CH_CLOSE_ROUND,  1'b1, 1'b1, ERR_UNCLOSED},
        '{8'h80,           1'b0, 1'b0, ERR_NONE},
        '{8'h7F,           1'b0, 1'b0, ERR_NONE},
        '{CH_OPEN_SQUARE,  1'b0, 1'b0, ERR_NONE},
        '{CH_CLOSE_SQUARE, 1'b1, 1'b0, ERR_NONE}
    };

    bracket_balance_checker_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_byte (i_char_byte),
        .i_is_last   (i_is_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_valid_res (o_valid_res),
        .o_error_code(o_error_code)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [7:0] open_char(input t_kind k);
        case (k)
            KIND_CURLY:  return CH_OPEN_CURLY;
            KIND_SQUARE: return CH_OPEN_SQUARE;
            default:     return CH_OPEN_ROUND;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input t_kind k);
        case (k)
            KIND_CURLY:  return CH_CLOSE_CURLY;
            KIND_SQUARE: return CH_CLOSE_SQUARE;
            default:     return CH_CLOSE_ROUND;
        endcase
    endfunction

    function automatic logic is_bracket(input logic [7:0] c);
        return c == CH_OPEN_ROUND || c == CH_CLOSE_ROUND || c == CH_OPEN_CURLY ||
               c == CH_CLOSE_CURLY || c == CH_OPEN_SQUARE || c == CH_CLOSE_SQUARE;
    endfunction

    function automatic t_kind pick_kind();
        return t_kind'($urandom_range(2));
    endfunction

    function automatic logic [7:0] pick_bracket();
        return $urandom_range(1) ? open_char(pick_kind()) : close_char(pick_kind());
    endfunction

    // a byte that is never a bracket
    function automatic logic [7:0] pick_filler();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        return is_bracket(c) ? 8'h20 : c;
    endfunction

    // step the stack model by one byte; gives the checker result on the last byte
    function automatic void step_stack(input logic [7:0] c, input logic last,
                                       output logic got, output t_err code);
        t_kind k;
        logic  opener;
        logic  closer;
        t_err  wrong;
        k = KIND_ROUND;
        opener = 1'b0;
        closer = 1'b0;
        wrong = ERR_NONE;
        got = 1'b0;
        code = ERR_NONE;
        case (c)
            CH_OPEN_ROUND:   begin k = KIND_ROUND;  opener = 1'b1; end
            CH_OPEN_CURLY:   begin k = KIND_CURLY;  opener = 1'b1; end
            CH_OPEN_SQUARE:  begin k = KIND_SQUARE; opener = 1'b1; end
            CH_CLOSE_ROUND:  begin k = KIND_ROUND;  closer = 1'b1; wrong = ERR_ROUND; end
            CH_CLOSE_CURLY:  begin k = KIND_CURLY;  closer = 1'b1; wrong = ERR_CURLY; end
            CH_CLOSE_SQUARE: begin k = KIND_SQUARE; closer = 1'b1; wrong = ERR_SQUARE; end
            default: ;
        endcase
        // once an error is latched the rest of the string is ignored
        if (latched_err == ERR_NONE) begin
            if (opener) begin
                if (open_count >= STACK_DEPTH) begin
                    latched_err = ERR_OVERFLOW;
                end else begin
                    open_kinds[open_count] = k;
                    open_count++;
                end
            end else if (closer) begin
                if (open_count == 0)
                    latched_err = ERR_EMPTY;
                else if (open_kinds[open_count - 1] != k)
                    latched_err = wrong;
                else
                    open_count--;
            end
        end
        if (last) begin
            got = 1'b1;
            code = latched_err;
            if (code == ERR_NONE && open_count != 0)
                code = ERR_UNCLOSED;
            open_count = 0;
            latched_err = ERR_NONE;
        end
    endfunction

    // one input transaction; called and returns at a falling edge
    task automatic send_char(input logic [7:0] c, input logic last,
                             input logic typed, input t_err typed_code);
        logic got;
        t_err code;
        while (idle_on && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_byte <= c;
        i_is_last   <= last;
        do @(posedge i_clk); while (o_in_stall);
        step_stack(c, last, got, code);
        if (got)
            expected_codes.push_back(typed ? typed_code : code);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic send_text();
        foreach (text_bytes[i])
            send_char(text_bytes[i], i == text_bytes.size() - 1, 1'b0, ERR_NONE);
    endtask

    // balanced-leaning string with filler; closes what is open most of the time
    task automatic build_nested(input int steps);
        t_kind open_q [$];
        int    r;
        text_bytes.delete();
        for (int i = 0; i < steps; i++) begin
            r = $urandom_range(9);
            if (r < 4 && open_q.size() < STACK_DEPTH) begin
                open_q.push_back(pick_kind());
                text_bytes.push_back(open_char(open_q[$]));
            end else if (r < 7 && open_q.size() > 0) begin
                text_bytes.push_back(close_char(open_q.pop_back()));
            end else begin
                text_bytes.push_back(pick_filler());
            end
        end
        if ($urandom_range(9) < 8)
            while (open_q.size() > 0)
                text_bytes.push_back(close_char(open_q.pop_back()));
    endtask

    // long run of openers, then closed in order; past the depth it overflows
    task automatic build_deep(input int depth);
        t_kind open_q [$];
        text_bytes.delete();
        for (int i = 0; i < depth; i++) begin
            open_q.push_back(pick_kind());
            text_bytes.push_back(open_char(open_q[$]));
        end
        while (open_q.size() > 0)
            text_bytes.push_back(close_char(open_q.pop_back()));
    endtask

    // random output stall
    always @(negedge i_clk) begin
        i_out_stall <= stall_on && ($urandom_range(99) < 24);
    end

    // result checker
    always @(posedge i_clk) begin
        t_err exp_code;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_codes.size() == 0) begin
                $error("result transaction with nothing expected: valid_res %0d error_code %0d",
                       o_valid_res, o_error_code);
                mismatch_count++;
            end else begin
                exp_code = expected_codes.pop_front();
                if (o_valid_res !== (exp_code == ERR_NONE)) begin
                    $error("valid_res mismatch: expected %0d, actual %0d",
                           exp_code == ERR_NONE, o_valid_res);
                    mismatch_count++;
                end
                if (o_error_code !== exp_code) begin
                    $error("error_code mismatch: expected %0d, actual %0d",
                           exp_code, o_error_code);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("bracket_balance_checker_core test failed");
            $finish;
        end
    end

    initial begin
        int pick;
        int strings_done;
        strings_done = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed strings
        for (int i = 0; i < NUM_ROWS; i++)
            send_char(directed_rows[i].ch, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].code);

        // random strings; a quiet stretch with no idling or stalls after the deep ones
        while (sent_items < ITEM_TARGET) begin
            idle_on  = !(sent_items >= 300 && sent_items < 400);
            stall_on = idle_on;
            pick = $urandom_range(99);
            if (strings_done == 0) begin
                build_deep(STACK_DEPTH + 1 + $urandom_range(2));
            end else if (strings_done == 1) begin
                build_deep(STACK_DEPTH);
            end else if (pick < 3) begin
                build_deep($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4));
            end else if (pick < 70) begin
                build_nested($urandom_range(1, 14));
            end else if (pick < 85) begin
                // nested string with one bracket swapped in at random
                build_nested($urandom_range(2, 14));
                text_bytes[$urandom_range(text_bytes.size() - 1)] = pick_bracket();
            end else begin
                text_bytes.delete();
                repeat ($urandom_range(1, 10))
                    text_bytes.push_back($urandom_range(1) ? pick_bracket()
                                                           : 8'($urandom_range(255)));
            end
            send_text();
            strings_done++;
        end
        i_in_valid <= 1'b0;

        // drain
        while (expected_codes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("bracket_balance_checker_core test passed");
        else
            $display("bracket_balance_checker_core test failed");
        $finish;
    end

endmodule
